>>> rtl/bcu_pkg.sv
// shared request and response types and operation codes for the bit count unit
package bcu_pkg;

  // operation codes; the one unused code yields an invalid response
  typedef enum logic [2:0] {
    OP_CLZ      = 3'd0,
    OP_CTZ      = 3'd1,
    OP_POPCOUNT = 3'd2,
    OP_PARITY   = 3'd3,
    OP_FFS      = 3'd4,
    OP_CLRSB    = 3'd5,
    OP_BSWAP32  = 3'd6
  } op_t;

  localparam int unsigned OperandWidth = 64;
  localparam int unsigned ResultWidth  = 32;
  localparam int unsigned CountWidth   = 7;

  // one request
  typedef struct packed {
    logic [2:0]                     operation;
    logic                           wide;
    logic signed [OperandWidth-1:0] operand;
  } req_t;

  // one response
  typedef struct packed {
    logic signed [ResultWidth-1:0] result;
    logic                          valid_res;
  } rsp_t;

endpackage

>>> rtl/bcu_lzc.sv
// leading zero counter over 64 bits, built as per-byte counts and a byte priority select
module bcu_lzc (
  input  logic [bcu_pkg::OperandWidth-1:0] din,
  output logic [bcu_pkg::CountWidth-1:0]   count
);
  import bcu_pkg::*;

  localparam int unsigned Bytes = OperandWidth / 8;

  logic [Bytes-1:0] nz;
  logic [3:0]       lz8 [Bytes];

  // leading zeros of one byte, 8 when the byte is zero
  function automatic logic [3:0] lzc8(input logic [7:0] b);
    logic [3:0] n;
    logic       found;
    n     = 4'd0;
    found = 1'b0;
    for (int k = 7; k >= 0; k--) begin
      if (b[k]) begin
        found = 1'b1;
      end else if (!found) begin
        n = n + 4'd1;
      end
    end
    return n;
  endfunction

  // per-byte counts, byte 0 is the most significant
  always_comb begin
    for (int i = 0; i < Bytes; i++) begin
      nz[i]  = |din[OperandWidth-1-8*i -: 8];
      lz8[i] = lzc8(din[OperandWidth-1-8*i -: 8]);
    end
  end

  // first non-zero byte from the top wins
  always_comb begin
    count = CountWidth'(OperandWidth);
    for (int i = Bytes - 1; i >= 0; i--) begin
      if (nz[i]) begin
        count = CountWidth'(8 * i) + CountWidth'(lz8[i]);
      end
    end
  end

endmodule

>>> rtl/bcu_core.sv
// operation datapath: masking, counts, parity, byte swap and result select
module bcu_core (
  input  bcu_pkg::req_t req,
  output bcu_pkg::rsp_t rsp
);
  import bcu_pkg::*;

  localparam int unsigned Half  = OperandWidth / 2;
  localparam int unsigned Bytes = OperandWidth / 8;

  op_t                     op;
  logic [OperandWidth-1:0] x;
  logic                    sign;
  logic [OperandWidth-1:0] y;
  logic [OperandWidth-1:0] lead_in;
  logic [OperandWidth-1:0] trail_src;
  logic [OperandWidth-1:0] trail_in;
  logic [CountWidth-1:0]   lead_cnt;
  logic [CountWidth-1:0]   trail_cnt;
  logic [CountWidth-1:0]   ones_cnt;
  logic                    is_zero;

  // ones in one byte
  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      n = n + 4'(b[k]);
    end
    return n;
  endfunction

  // operand masked to the selected width
  assign op      = op_t'(req.operation);
  assign x       = req.wide ? OperandWidth'(req.operand)
                            : {{Half{1'b0}}, req.operand[Half-1:0]};
  assign is_zero = (x == '0);
  assign sign    = req.wide ? req.operand[OperandWidth-1] : req.operand[Half-1];

  // clrsb folds a negative value onto its complement
  assign y = sign ? (req.wide ? ~x : {{Half{1'b0}}, ~x[Half-1:0]}) : x;

  // narrow mode pads with a one just past the field so counts stop at 32
  always_comb begin
    if (op == OP_CLRSB) begin
      lead_in = req.wide ? y : {y[Half-1:0], 1'b1, {(Half-1){1'b0}}};
    end else begin
      lead_in = req.wide ? x : {x[Half-1:0], 1'b1, {(Half-1){1'b0}}};
    end
    trail_src = req.wide ? x : {{(Half-1){1'b0}}, 1'b1, x[Half-1:0]};
    for (int i = 0; i < OperandWidth; i++) begin
      trail_in[i] = trail_src[OperandWidth-1-i];
    end
  end

  bcu_lzc u_lead (
    .din   (lead_in),
    .count (lead_cnt)
  );

  // trailing zeros as leading zeros of the bit-reversed operand
  bcu_lzc u_trail (
    .din   (trail_in),
    .count (trail_cnt)
  );

  // population count as a sum of byte counts
  always_comb begin
    ones_cnt = '0;
    for (int i = 0; i < Bytes; i++) begin
      ones_cnt = ones_cnt + CountWidth'(pop8(x[8*i +: 8]));
    end
  end

  // result select
  always_comb begin
    rsp.result    = '0;
    rsp.valid_res = 1'b1;
    unique case (op)
      OP_CLZ: begin
        if (is_zero) rsp.valid_res = 1'b0;
        else         rsp.result    = ResultWidth'(lead_cnt);
      end
      OP_CTZ: begin
        if (is_zero) rsp.valid_res = 1'b0;
        else         rsp.result    = ResultWidth'(trail_cnt);
      end
      OP_POPCOUNT: rsp.result = ResultWidth'(ones_cnt);
      OP_PARITY:   rsp.result = ResultWidth'(^x);
      OP_FFS: begin
        if (!is_zero) rsp.result = ResultWidth'(trail_cnt) + ResultWidth'(1);
      end
      OP_CLRSB: rsp.result = ResultWidth'(lead_cnt) - ResultWidth'(1);
      OP_BSWAP32: begin
        if (req.wide) rsp.valid_res = 1'b0;
        else rsp.result = {x[7:0], x[15:8], x[23:16], x[31:24]};
      end
      default: rsp.valid_res = 1'b0;
    endcase
  end

endmodule

>>> rtl/bit_count_unit.sv
// top level of the bit count unit: request register, datapath, response register
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (bcu_pkg::req_t)
//   response| rsp_valid | rsp_stall | rsp (bcu_pkg::rsp_t)
//
// one request per cycle is taken while req_stall is low; it passes from the request register
// to the response register, where its response is offered until it leaves
// the path between the two registers is the datapath in bcu_core: two 64-bit
// leading zero counters and a byte-wise population count
// rst clears both stage valid flags; payload registers are not reset
// a stalled response holds; req_stall rises only when both stages are full
module bit_count_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bcu_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bcu_pkg::rsp_t rsp
);
  import bcu_pkg::*;

  logic s1_valid;
  req_t s1_req;
  rsp_t s1_rsp;
  logic advance;

  // the output register can take a new response
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !advance;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1_req <= req;
    end
  end

  bcu_core u_core (
    .req (s1_req),
    .rsp (s1_rsp)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      rsp <= s1_rsp;
    end
  end

  // full pipeline with a stalled output pushes back on requests
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && rsp_valid && rsp_stall) |-> req_stall)
    else $error("request taken while both stages are blocked");

  // a taken request occupies the first stage next cycle
  a_req_loaded: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> s1_valid)
    else $error("accepted request lost");

  // an item moving on shows up as a response
  a_rsp_loaded: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> rsp_valid)
    else $error("item lost between stages");

  // an invalid response carries a zero result
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.valid_res) |-> (rsp.result == '0))
    else $error("invalid response with non-zero result");

endmodule

>>> tb/bit_count_unit_checker.sv
// response checker for the bit count unit: predicts each request's response and compares
`timescale 1ns / 1ps

module bit_count_unit_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  bcu_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  bcu_pkg::rsp_t rsp,
  output int unsigned   failures,
  output int unsigned   pending,
  output int unsigned   checked
);
  import bcu_pkg::*;

  rsp_t expected_rsps[$];

  // one line per mismatch, and a count
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, predicted %h", $realtime, what, got, want);
    failures++;
  endtask

  // leading zeros of v within the low w bits; w when v is zero
  function automatic int unsigned lead_zeros_in(input logic [63:0] v, input int unsigned w);
    int unsigned n;
    n = w;
    for (int i = 0; i < w; i++) begin
      if (v[i]) n = w - 1 - i;
    end
    return n;
  endfunction

  // expected response of one request
  function automatic rsp_t predict_bits(input req_t r);
    logic [63:0] mask;
    logic [63:0] x;
    int unsigned w;
    int unsigned trail;
    int unsigned ones_cnt;
    rsp_t p;
    w        = r.wide ? OperandWidth : OperandWidth / 2;
    mask     = r.wide ? '1 : 64'h0000_0000_FFFF_FFFF;
    x        = r.operand & mask;
    trail    = w;
    ones_cnt = 0;
    for (int i = int'(w) - 1; i >= 0; i--) begin
      if (x[i]) trail = i;
    end
    for (int i = 0; i < OperandWidth; i++) begin
      ones_cnt += 32'(x[i]);
    end
    p.result    = '0;
    p.valid_res = 1'b1;
    case (r.operation)
      OP_CLZ: begin
        if (x == 64'd0) p.valid_res = 1'b0;
        else p.result = lead_zeros_in(x, w);
      end
      OP_CTZ: begin
        if (x == 64'd0) p.valid_res = 1'b0;
        else p.result = trail;
      end
      OP_POPCOUNT: p.result = ones_cnt;
      OP_PARITY:   p.result = ones_cnt % 2;
      OP_FFS:      p.result = (x == 64'd0) ? 0 : trail + 1;
      // negative values are inverted so the count runs over copies of the sign
      OP_CLRSB:    p.result = lead_zeros_in(x[w-1] ? (~x & mask) : x, w) - 1;
      OP_BSWAP32: begin
        if (r.wide) p.valid_res = 1'b0;
        else p.result = {x[7:0], x[15:8], x[23:16], x[31:24]};
      end
      default: p.valid_res = 1'b0;
    endcase
    return p;
  endfunction

  // compare responses against the oldest prediction, then queue new requests
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      expected_rsps.delete();
      failures = 0;
      checked  = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("response with no request outstanding", rsp.result, '0);
        end else begin
          want = expected_rsps.pop_front();
          checked++;
          if (rsp.result !== want.result) begin
            report_mismatch("result", rsp.result, want.result);
          end
          if (rsp.valid_res !== want.valid_res) begin
            report_mismatch("valid_res", 32'(rsp.valid_res), 32'(want.valid_res));
          end
        end
      end
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(predict_bits(req));
      end
    end
    pending = expected_rsps.size();
  end

endmodule

>>> tb/bit_count_unit_test.sv
// top of the bit count unit testbench: clock, reset, request and stall stimulus, verdict
`timescale 1ns / 1ps

module bit_count_unit_test;
  import bcu_pkg::*;

  // the one operation code with no operation behind it
  localparam logic [2:0] OpUnused = 3'd7;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned NumPhases = 5;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int unsigned failures;
  int unsigned pending;
  int unsigned checked;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned sent_count = 0;
  int unsigned stuck_cycles = 0;

  logic [2:0] all_ops[8] = '{OP_CLZ, OP_CTZ, OP_POPCOUNT, OP_PARITY,
                             OP_FFS, OP_CLRSB, OP_BSWAP32, OpUnused};

  // idle and stall mix of each random phase, and its length in requests
  int unsigned phase_idle[NumPhases]  = '{0, 57, 0, 29, 0};
  int unsigned phase_stall[NumPhases] = '{0, 0, 57, 29, 0};
  int unsigned phase_len[NumPhases]   = '{300, 200, 200, 200, 125};

  always #10 clk = ~clk;

  bit_count_unit dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  bit_count_unit_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .failures (failures),
    .pending  (pending),
    .checked  (checked)
  );

  // response back-pressure
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // give up when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WatchdogLimit) begin
        $display("no request or response moved for %0d cycles", WatchdogLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic req_t make_req(input logic [2:0] op, input logic wide,
                                    input logic [63:0] operand);
    req_t r;
    r.operation = op;
    r.wide      = wide;
    r.operand   = operand;
    return r;
  endfunction

  // operands shaped to spread the counts over their whole range
  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(6))
      0: v = v >> $urandom_range(63);
      1: v = v << $urandom_range(63);
      2: v = 64'd1 << $urandom_range(63);
      3: v = ~(v >> $urandom_range(63));
      4: v = v[0] ? '1 : 64'd0;
      // zero or all-ones low word under junk upper bits
      5: v = {v[63:32], (v[0] ? 32'hFFFF_FFFF : 32'h0)};
      default: ;
    endcase
    return v;
  endfunction

  // called just after a falling edge; returns just after a falling edge, once the request has been taken
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sent_count++;
    @(negedge clk);
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero operand for every code at both widths
    foreach (all_ops[k]) begin
      send_req(make_req(all_ops[k], 1'b0, 64'd0));
      send_req(make_req(all_ops[k], 1'b1, 64'd0));
    end
    // single corner cases
    send_req(make_req(OP_CLZ, 1'b1, 64'h8000_0000_0000_0000));
    send_req(make_req(OP_CLZ, 1'b0, 64'hFFFF_FFFF_0000_0001));
    send_req(make_req(OP_CTZ, 1'b1, 64'h8000_0000_0000_0000));
    send_req(make_req(OP_POPCOUNT, 1'b1, '1));
    send_req(make_req(OP_PARITY, 1'b0, 64'h0000_0001_0000_0007));
    send_req(make_req(OP_FFS, 1'b1, 64'h8000_0000_0000_0000));
    send_req(make_req(OP_CLRSB, 1'b1, '1));
    send_req(make_req(OP_CLRSB, 1'b0, 64'h0000_0000_8000_0000));
    send_req(make_req(OP_BSWAP32, 1'b0, 64'hDEAD_BEEF_1234_5678));

    // random requests under each idle and stall mix
    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      repeat (phase_len[ph]) begin
        send_req(make_req(3'($urandom_range(7)), 1'($urandom_range(1)), random_operand()));
      end
    end
    req_valid <= 1'b0;
    stall_pct = 0;

    // drain until no prediction is pending, then let the two pipeline stages settle
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("%0d requests sent: zero operands and corner cases for all eight codes,",
             sent_count);
    $display("then random operands at both widths under four idle/stall mixes; %0d checked",
             checked);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
